@@ design/u8d_pkg.sv @@
// Shared types and constants for the UTF-8 stream decoder.
`default_nettype none
package u8d_pkg;

  localparam logic [20:0] REPL_CP   = 21'h00FFFD;
  localparam logic [20:0] MAX_CP    = 21'h10FFFF;
  localparam logic [20:0] SURR_LO   = 21'h00D800;
  localparam logic [20:0] SURR_HI   = 21'h00DFFF;
  localparam int          JOB_DEPTH = 4;
  localparam int          JPTR_W    = $clog2(JOB_DEPTH);

  typedef struct packed {
    logic [2:0]  repl_cnt;
    logic        has_cp;
    logic [20:0] cp;
    logic        last;
  } job_t;

  function automatic logic [20:0] seq_min(input logic [1:0] total);
    logic [20:0] m;
    unique case (total)
      2'd1:    m = 21'h000080;
      2'd2:    m = 21'h000800;
      2'd3:    m = 21'h010000;
      default: m = 21'h000000;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

@@ design/u8d_front.sv @@
// Byte classifier and sequence assembler; issues one job per resolving byte.
`default_nettype none
module u8d_front
  import u8d_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte_value,
  input  wire logic       in_last_byte,
  input  wire logic       job_full,
  output logic            job_push,
  output job_t            job
);

  logic [1:0]  total_r, total_nxt;
  logic [1:0]  taken_r, taken_nxt;
  logic [20:0] pv_r, pv_nxt;
  logic        accept;

  assign in_ready = !job_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    logic        fresh;
    logic [1:0]  tinc;
    logic [20:0] pv;
    fresh     = 1'b1;
    tinc      = taken_r + 2'd1;
    pv        = {pv_r[14:0], in_byte_value[5:0]};
    total_nxt = total_r;
    taken_nxt = taken_r;
    pv_nxt    = pv_r;
    job       = '0;
    job.last  = in_last_byte;

    if (total_r != 2'd0) begin
      if (in_byte_value[7:6] == 2'b10) begin
        fresh = 1'b0;
        if (tinc == total_r) begin
          if (pv < seq_min(total_r) || pv > MAX_CP || (pv >= SURR_LO && pv <= SURR_HI)) begin
            job.repl_cnt = {1'b0, total_r} + 3'd1;
          end else begin
            job.has_cp = 1'b1;
            job.cp     = pv;
          end
          total_nxt = 2'd0;
          taken_nxt = 2'd0;
          pv_nxt    = '0;
        end else if (in_last_byte) begin
          job.repl_cnt = {1'b0, tinc} + 3'd1;
          total_nxt    = 2'd0;
          taken_nxt    = 2'd0;
          pv_nxt       = '0;
        end else begin
          taken_nxt = tinc;
          pv_nxt    = pv;
        end
      end else begin
        job.repl_cnt = {1'b0, taken_r} + 3'd1;
        total_nxt    = 2'd0;
        taken_nxt    = 2'd0;
        pv_nxt       = '0;
      end
    end

    if (fresh) begin
      if (!in_byte_value[7]) begin
        job.has_cp = 1'b1;
        job.cp     = {13'd0, in_byte_value};
      end else if (in_byte_value[7:5] == 3'b110 && !in_last_byte) begin
        total_nxt = 2'd1;
        taken_nxt = 2'd0;
        pv_nxt    = {16'd0, in_byte_value[4:0]};
      end else if (in_byte_value[7:4] == 4'b1110 && !in_last_byte) begin
        total_nxt = 2'd2;
        taken_nxt = 2'd0;
        pv_nxt    = {17'd0, in_byte_value[3:0]};
      end else if (in_byte_value[7:3] == 5'b11110 && !in_last_byte) begin
        total_nxt = 2'd3;
        taken_nxt = 2'd0;
        pv_nxt    = {18'd0, in_byte_value[2:0]};
      end else begin
        job.has_cp = 1'b1;
        job.cp     = REPL_CP;
      end
    end

    if (in_last_byte) begin
      total_nxt = 2'd0;
      taken_nxt = 2'd0;
      pv_nxt    = '0;
    end
  end

  assign job_push = accept && (job.repl_cnt != 3'd0 || job.has_cp);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= 2'd0;
      taken_r <= 2'd0;
      pv_r    <= '0;
    end else if (accept) begin
      total_r <= total_nxt;
      taken_r <= taken_nxt;
      pv_r    <= pv_nxt;
    end
  end

endmodule
`default_nettype wire

@@ design/u8d_fifo.sv @@
// Short job queue between the classifier and the result sequencer.
`default_nettype none
module u8d_fifo
  import u8d_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  job_t      push_job,
  output logic      full,
  input  wire logic pop,
  output logic      not_empty,
  output job_t      head
);

  job_t              slots_r [JOB_DEPTH];
  logic [JPTR_W-1:0] wptr_r, rptr_r;
  logic [JPTR_W:0]   cnt_r;

  assign full      = (cnt_r == (JPTR_W+1)'(JOB_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = slots_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ design/u8d_back.sv @@
// Result sequencer: expands jobs into results, tracks rune count and wanted hit.
`default_nettype none
module u8d_back
  import u8d_pkg::*;
#(
  parameter longint MAX_RUNES = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [15:0] wanted_index,
  input  wire logic        job_valid,
  input  job_t             job,
  output logic             job_pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [20:0]      out_code_point,
  output logic [15:0]      out_rune_index,
  output logic             out_is_wanted,
  output logic             out_run_end,
  output logic             out_string_end,
  output logic [16:0]      out_rune_count,
  output logic             out_out_of_range
);

  localparam int CW = $clog2(MAX_RUNES + 1);
  localparam int EW = CW + 17;

  logic [CW-1:0] cnt_r, cnt_inc;
  logic          seen_r, seen_now;
  logic [1:0]    k_r;
  logic [2:0]    total;
  logic          final_res, load, hit, str_end;
  logic [EW-1:0] cnt_ext, inc_ext;

  logic          valid_r;
  logic [20:0]   cp_r;
  logic [15:0]   idx_r;
  logic          wanted_r, run_end_r, str_end_r, oor_r;
  logic [16:0]   count_r;

  assign total     = job.repl_cnt + {2'd0, job.has_cp};
  assign final_res = ({1'b0, k_r} + 3'd1) == total;
  assign load      = job_valid && (!valid_r || out_ready);
  assign job_pop   = load && final_res;
  assign str_end   = final_res && job.last;

  assign cnt_ext  = {17'd0, cnt_r};
  assign hit      = (cnt_ext == EW'(wanted_index));
  assign seen_now = seen_r || hit;
  assign cnt_inc  = (cnt_ext < EW'(MAX_RUNES)) ? cnt_r + 1'b1 : cnt_r;
  assign inc_ext  = {17'd0, cnt_inc};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      k_r     <= 2'd0;
      cnt_r   <= '0;
      seen_r  <= 1'b0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
      if (load) begin
        k_r <= final_res ? 2'd0 : k_r + 2'd1;
        if (str_end) begin
          cnt_r  <= '0;
          seen_r <= 1'b0;
        end else begin
          cnt_r  <= cnt_inc;
          seen_r <= seen_now;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cp_r      <= ({1'b0, k_r} < job.repl_cnt) ? REPL_CP : job.cp;
      idx_r     <= (cnt_ext > EW'(16'hFFFF)) ? 16'hFFFF : cnt_ext[15:0];
      wanted_r  <= hit;
      run_end_r <= final_res;
      str_end_r <= str_end;
      count_r   <= str_end ? inc_ext[16:0] : 17'd0;
      oor_r     <= str_end && !seen_now;
    end
  end

  assign out_valid        = valid_r;
  assign out_code_point   = cp_r;
  assign out_rune_index   = idx_r;
  assign out_is_wanted    = wanted_r;
  assign out_run_end      = run_end_r;
  assign out_string_end   = str_end_r;
  assign out_rune_count   = count_r;
  assign out_out_of_range = oor_r;

endmodule
`default_nettype wire

@@ design/utf8_stream_decoder.sv @@
// Top level of the UTF-8 stream decoder with replacement characters.
// Takes one byte per cycle while the job queue has room. Each byte is
// classified on acceptance and any results it resolves are queued as one
// job (up to four results) in a four-entry queue; the sequencer behind it
// drives one result per cycle into a registered output while out_ready is
// high. Well-formed input then sustains one byte per cycle; the results of
// an ill-formed run leave in turn; input stalls only when the queue is full.
// No clearing pass after reset. wanted_index is written through cfg_we and
// must only change while the block is idle.
`default_nettype none
module utf8_stream_decoder
  import u8d_pkg::*;
#(
  parameter longint MAX_RUNES = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte_value,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [20:0]      out_code_point,
  output logic [15:0]      out_rune_index,
  output logic             out_is_wanted,
  output logic             out_run_end,
  output logic             out_string_end,
  output logic [16:0]      out_rune_count,
  output logic             out_out_of_range,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wanted_index
);

  logic [15:0] wanted_r;
  logic        job_push, job_full, job_pop, job_avail;
  job_t        push_job, head_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_r <= 16'd0;
    end else if (cfg_we) begin
      wanted_r <= cfg_wanted_index;
    end
  end

  u8d_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte_value (in_byte_value),
    .in_last_byte  (in_last_byte),
    .job_full      (job_full),
    .job_push      (job_push),
    .job           (push_job)
  );

  u8d_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_job  (push_job),
    .full      (job_full),
    .pop       (job_pop),
    .not_empty (job_avail),
    .head      (head_job)
  );

  u8d_back #(
    .MAX_RUNES (MAX_RUNES)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .wanted_index     (wanted_r),
    .job_valid        (job_avail),
    .job              (head_job),
    .job_pop          (job_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_code_point   (out_code_point),
    .out_rune_index   (out_rune_index),
    .out_is_wanted    (out_is_wanted),
    .out_run_end      (out_run_end),
    .out_string_end   (out_string_end),
    .out_rune_count   (out_rune_count),
    .out_out_of_range (out_out_of_range)
  );

endmodule
`default_nettype wire
